### design/lapl_pkg.sv
// ---------------------------------------------------------------------------
// lapl_pkg: shared types and constants for the Laplace edge detector
// Pixel and position widths, configuration register codes, the stage
// structs passed between modules and the kernel response function.
// ---------------------------------------------------------------------------
package lapl_pkg;

	localparam int PIXEL_BITS    = 8;
	localparam int MAX_WIDTH     = 2048;
	localparam int COL_BITS      = $clog2(MAX_WIDTH);
	localparam int ROW_BITS      = 16;
	localparam int WREG_BITS     = COL_BITS + 1;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int MIN_SIZE      = 3;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int ACC_BITS      = PIXEL_BITS + 3;

	// configuration register codes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// position and flags of the pixel held in stage 1
	typedef struct packed {
		logic                emit;
		logic                last;
		logic [COL_BITS-1:0] addr;
		logic [ROW_BITS-1:0] center_row;
		logic [COL_BITS-1:0] center_col;
	} pos_t;

	// line buffer taps for the pixel held in stage 1
	typedef struct packed {
		logic [PIXEL_BITS-1:0] px;
		logic [PIXEL_BITS-1:0] mid;
		logic [PIXEL_BITS-1:0] top;
	} taps_t;

	// four-neighbour response, negative and overflow both saturate to full scale
	function automatic logic [PIXEL_BITS-1:0] laplace_map(
		input logic [PIXEL_BITS-1:0] ctr,
		input logic [PIXEL_BITS-1:0] upr,
		input logic [PIXEL_BITS-1:0] lwr,
		input logic [PIXEL_BITS-1:0] lft,
		input logic [PIXEL_BITS-1:0] rgt
	);
		logic signed [ACC_BITS-1:0] acc;
		logic        [PIXEL_BITS-1:0] res;
		acc = $signed({1'b0, ctr, 2'b00}) - $signed({3'b000, upr})
			- $signed({3'b000, lwr}) - $signed({3'b000, lft})
			- $signed({3'b000, rgt});
		if (acc[ACC_BITS-1] || (|acc[ACC_BITS-2:PIXEL_BITS]))
			res = '1;
		else
			res = acc[PIXEL_BITS-1:0];
		return res;
	endfunction

endpackage

### design/lapl_if.sv
// ---------------------------------------------------------------------------
// lapl interfaces: valid/ready channels of the Laplace edge detector
// Pixel input stream, edge result stream and configuration write channel.
// ---------------------------------------------------------------------------
interface lapl_pix_if;
	import lapl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface lapl_edge_if;
	import lapl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] edge_value;
	logic [ROW_BITS-1:0]   center_row;
	logic [COL_BITS-1:0]   center_col;
	logic                  frame_last;
	modport source (output valid, output edge_value, output center_row,
		output center_col, output frame_last, input ready);
	modport sink   (input valid, input edge_value, input center_row,
		input center_col, input frame_last, output ready);
endinterface

interface lapl_cfg_if;
	import lapl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### design/lapl_raster.sv
// ---------------------------------------------------------------------------
// lapl_raster: frame size registers and raster position counters
// Holds the configured frame size, tracks the position of the next pixel
// and registers the position flags of the accepted pixel into stage 1.
// ---------------------------------------------------------------------------
module lapl_raster (
	input  logic          clk,
	input  logic          arst_n,
	lapl_cfg_if.sink      cfg,
	input  logic          accept,
	input  logic          advance,
	output logic [lapl_pkg::COL_BITS-1:0] rd_col,
	output logic          valid_s1,
	output lapl_pkg::pos_t pos_s1
);
	import lapl_pkg::*;

	logic [WREG_BITS-1:0] width_q;
	logic [ROW_BITS-1:0]  height_q;
	logic [WREG_BITS-1:0] eff_w;
	logic [ROW_BITS-1:0]  eff_h;
	logic [COL_BITS-1:0]  col_q;
	logic [ROW_BITS-1:0]  row_q;
	logic                 col_end;
	logic                 row_end;

	assign cfg.ready = 1'b1;

	// column of the next pixel, used as the row memory read address
	assign rd_col = col_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WREG_BITS'(WIDTH_RESET);
			height_q <= ROW_BITS'(HEIGHT_RESET);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[WREG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size, out-of-range values clamped
	always_comb begin
		if (width_q < WREG_BITS'(MIN_SIZE))
			eff_w = WREG_BITS'(MIN_SIZE);
		else if (width_q > WREG_BITS'(MAX_WIDTH))
			eff_w = WREG_BITS'(MAX_WIDTH);
		else
			eff_w = width_q;
		if (height_q < ROW_BITS'(MIN_SIZE))
			eff_h = ROW_BITS'(MIN_SIZE);
		else
			eff_h = height_q;
	end

	// end of row and end of frame detection
	assign col_end = (WREG_BITS'(col_q) + WREG_BITS'(1)) >= eff_w;
	assign row_end = ((ROW_BITS+1)'(row_q) + (ROW_BITS+1)'(1)) >= (ROW_BITS+1)'(eff_h);

	// raster counters, step on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	// stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	// stage 1 position, result belongs to the pixel one row up and one column left
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1.emit       <= (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
			pos_s1.last       <= row_end && col_end;
			pos_s1.addr       <= col_q;
			pos_s1.center_row <= row_q - ROW_BITS'(1);
			pos_s1.center_col <= col_q - COL_BITS'(1);
		end
	end

endmodule

### design/lapl_line_buf.sv
// ---------------------------------------------------------------------------
// lapl_line_buf: two row memories of the Laplace edge detector
// Reads the previous and older row at the column of an accepted pixel and
// writes them back shifted by one row when that pixel leaves stage 1.
// ---------------------------------------------------------------------------
module lapl_line_buf (
	input  logic                            clk,
	input  logic                            accept,
	input  logic [lapl_pkg::COL_BITS-1:0]   rd_addr,
	input  logic [lapl_pkg::PIXEL_BITS-1:0] pixel_in,
	input  logic                            advance,
	input  logic [lapl_pkg::COL_BITS-1:0]   wr_addr,
	output lapl_pkg::taps_t                 taps_s1
);
	import lapl_pkg::*;

	logic [PIXEL_BITS-1:0] prev_mem  [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];

	// registered reads, held while stage 1 stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			taps_s1.mid <= prev_mem[rd_addr];
			taps_s1.top <= older_mem[rd_addr];
			taps_s1.px  <= pixel_in;
		end
	end

	// previous row gets the new pixel
	always_ff @(posedge clk) begin
		if (advance)
			prev_mem[wr_addr] <= taps_s1.px;
	end

	// older row gets what the previous row held
	always_ff @(posedge clk) begin
		if (advance)
			older_mem[wr_addr] <= taps_s1.mid;
	end

endmodule

### design/lapl_kernel.sv
// ---------------------------------------------------------------------------
// lapl_kernel: window registers, response and result register
// Shifts the 3x3 cross window, computes the four-neighbour response and
// holds the result request until the sink takes it.
// ---------------------------------------------------------------------------
module lapl_kernel (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  lapl_pkg::pos_t  pos_s1,
	input  lapl_pkg::taps_t taps_s1,
	lapl_edge_if.source     edges
);
	import lapl_pkg::*;

	logic [PIXEL_BITS-1:0] left_q;
	logic [PIXEL_BITS-1:0] ctr_q;
	logic [PIXEL_BITS-1:0] upr_q;
	logic [PIXEL_BITS-1:0] lwr_q;
	logic [PIXEL_BITS-1:0] resp;
	logic                  valid_q;
	logic [PIXEL_BITS-1:0] edge_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [COL_BITS-1:0]   col_q;
	logic                  last_q;

	// window shift as the stage 1 pixel moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ctr_q  <= '0;
			upr_q  <= '0;
			lwr_q  <= '0;
		end else if (advance) begin
			left_q <= ctr_q;
			ctr_q  <= taps_s1.mid;
			upr_q  <= taps_s1.top;
			lwr_q  <= taps_s1.px;
		end
	end

	// right neighbour comes straight from the middle row tap
	assign resp = laplace_map(ctr_q, upr_q, lwr_q, left_q, taps_s1.mid);

	// result request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance && pos_s1.emit)
			valid_q <= 1'b1;
		else if (edges.ready)
			valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && pos_s1.emit) begin
			edge_q <= resp;
			row_q  <= pos_s1.center_row;
			col_q  <= pos_s1.center_col;
			last_q <= pos_s1.last;
		end
	end

	assign edges.valid      = valid_q;
	assign edges.edge_value = edge_q;
	assign edges.center_row = row_q;
	assign edges.center_col = col_q;
	assign edges.frame_last = last_q;

endmodule

### design/laplace_edge_detect_3x3_unit.sv
// ---------------------------------------------------------------------------
// laplace_edge_detect_3x3_unit: streaming four-neighbour Laplace edge detector
// Takes gray pixels in raster order and emits one edge result per interior
// pixel with its row, column and an end-of-frame mark.
// ---------------------------------------------------------------------------
// Usage: pixels enter in raster order at a sustained rate of one per clock
// unless a blocked result register stalls stage 1; the result for centre
// (r-1, c-1) leaves after pixel (r, c) passes the registered row memory
// read and the result register. Border positions give no result. Frame
// size comes from register 0 (width, clamped to 3..2048) and register 1
// (height, at least 3); write them only while no pixel is in flight. Row
// memories need no clearing after reset, and position counters wrap to the
// next frame after the last pixel of a frame.
module laplace_edge_detect_3x3_unit (
	input  logic        clk,
	input  logic        arst_n,
	lapl_pix_if.sink    pixels,
	lapl_edge_if.source edges,
	lapl_cfg_if.sink    cfg
);
	import lapl_pkg::*;

	logic                accept;
	logic                advance;
	logic                valid_s1;
	logic [COL_BITS-1:0] rd_col;
	pos_t                pos_s1;
	taps_t               taps_s1;

	// stage 1 moves on unless it carries a result and the result register is blocked
	assign advance      = valid_s1 && (!pos_s1.emit || !edges.valid || edges.ready);
	assign pixels.ready = !valid_s1 || advance;
	assign accept       = pixels.valid && pixels.ready;

	lapl_raster u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.advance  (advance),
		.rd_col   (rd_col),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1)
	);

	lapl_line_buf u_line_buf (
		.clk      (clk),
		.accept   (accept),
		.rd_addr  (rd_col),
		.pixel_in (pixels.pixel),
		.advance  (advance),
		.wr_addr  (pos_s1.addr),
		.taps_s1  (taps_s1)
	);

	lapl_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.pos_s1  (pos_s1),
		.taps_s1 (taps_s1),
		.edges   (edges)
	);

endmodule

### design/lapl_checker.sv
// ---------------------------------------------------------------------------
// lapl_checker: port-level checks for the Laplace edge detector
// Watches the pixel and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module lapl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lapl_pkg::PIXEL_BITS-1:0] out_edge,
	input logic [lapl_pkg::ROW_BITS-1:0]   out_row,
	input logic [lapl_pkg::COL_BITS-1:0]   out_col,
	input logic                            out_last
);
	import lapl_pkg::*;

	logic in_acc;
	logic out_acc;
	logic first_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// next result opens a frame after reset or after a frame's last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_q <= 1'b1;
		else if (out_acc)
			first_q <= out_last;
	end

	// a stalled result request holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_edge) && $stable(out_row)
			&& $stable(out_col) && $stable(out_last))
		else $error("result request changed while stalled");

	// first result of a frame is the top-left interior pixel
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && first_q |-> out_row == ROW_BITS'(1) && out_col == COL_BITS'(1))
		else $error("frame does not start at the first interior pixel");

	// results never lie on the top or left border
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != '0 && out_col != '0)
		else $error("result on the border");

	// a fresh result request traces back to a pixel taken through stage 1 and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("result without a matching pixel");

endmodule

bind laplace_edge_detect_3x3_unit lapl_checker u_lapl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (edges.valid),
	.out_ready (edges.ready),
	.out_edge  (edges.edge_value),
	.out_row   (edges.center_row),
	.out_col   (edges.center_col),
	.out_last  (edges.frame_last)
);
